>>> design/mepc_pkg.sv
`timescale 1ns / 1ps
package mepc_pkg;

  // largest frame side the counters cover
  localparam int MAX_DIM = 4096;
  localparam int DIM_W   = $clog2(MAX_DIM);
  localparam int CFG_W   = 13;
  localparam int PIX_W   = 8;
  localparam int IDX_W   = 2;
  localparam int SUM_W   = DIM_W + 2;

  // register indexes
  localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 13'd640;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 13'd480;

  // one configuration beat
  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] index;
    logic [CFG_W-1:0] data;
  } cfg_wr_t;

  // one frame result
  typedef struct packed {
    logic [DIM_W-1:0] center_row;
    logic [DIM_W-1:0] center_col;
    logic             found;
  } res_t;

  // zero counts as one, oversize counts as the maximum
  function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
    logic [CFG_W-1:0] r;
    r = v;
    if (v == '0) r = CFG_W'(1);
    else if (v > CFG_W'(MAX_DIM)) r = CFG_W'(MAX_DIM);
    return r;
  endfunction

endpackage

>>> design/mepc_tracker.sv
`timescale 1ns / 1ps
module mepc_tracker (
  input  logic                      clk,
  input  logic                      rst,
  input  mepc_pkg::cfg_wr_t         cfg_wr,
  input  logic                      step,
  input  logic [mepc_pkg::PIX_W-1:0] pix,
  output logic                      frame_end,
  output mepc_pkg::res_t            res
);
  import mepc_pkg::*;

  logic [CFG_W-1:0] frame_width, frame_height;
  logic [CFG_W-1:0] w, h;

  logic [DIM_W-1:0] row_count, col_count;
  logic             any_hit;
  logic [DIM_W-1:0] top_row, bottom_row, left_col, right_col;
  logic [DIM_W-1:0] first_hit_col, last_hit_col, left_col_row, right_col_row;

  logic             any_hit_next;
  logic [DIM_W-1:0] top_row_next, bottom_row_next, left_col_next, right_col_next;
  logic [DIM_W-1:0] first_hit_col_next, last_hit_col_next;
  logic [DIM_W-1:0] left_col_row_next, right_col_row_next;

  logic             fg, end_col, end_row;
  logic [SUM_W-1:0] sum_row, sum_col;

  // size registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RST;
      frame_height <= FRAME_HEIGHT_RST;
    end else if (cfg_wr.valid) begin
      unique case (cfg_wr.index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_wr.data;
        REG_FRAME_HEIGHT: frame_height <= cfg_wr.data;
        default: ;
      endcase
    end
  end

  assign w = clamp_dim(frame_width);
  assign h = clamp_dim(frame_height);

  // end of row / frame for the current position
  assign end_col   = ({1'b0, col_count} + CFG_W'(1)) >= w;
  assign end_row   = ({1'b0, row_count} + CFG_W'(1)) >= h;
  assign frame_end = end_col && end_row;

  // extremes including the current pixel
  assign fg = |pix;
  always_comb begin
    any_hit_next       = any_hit;
    top_row_next       = top_row;
    bottom_row_next    = bottom_row;
    left_col_next      = left_col;
    right_col_next     = right_col;
    first_hit_col_next = first_hit_col;
    last_hit_col_next  = last_hit_col;
    left_col_row_next  = left_col_row;
    right_col_row_next = right_col_row;
    if (fg) begin
      if (!any_hit) begin
        top_row_next       = row_count;
        first_hit_col_next = col_count;
        left_col_next      = col_count;
        right_col_next     = col_count;
      end
      bottom_row_next   = row_count;
      last_hit_col_next = col_count;
      // ties count as a hit
      if (col_count <= left_col_next) begin
        left_col_next     = col_count;
        left_col_row_next = row_count;
      end
      if (col_count >= right_col_next) begin
        right_col_next     = col_count;
        right_col_row_next = row_count;
      end
      any_hit_next = 1'b1;
    end
  end

  // centre: truncated mean of four values
  assign sum_row = SUM_W'(top_row_next) + SUM_W'(bottom_row_next)
                 + SUM_W'(left_col_row_next) + SUM_W'(right_col_row_next);
  assign sum_col = SUM_W'(left_col_next) + SUM_W'(right_col_next)
                 + SUM_W'(first_hit_col_next) + SUM_W'(last_hit_col_next);

  always_comb begin
    res.found      = any_hit_next;
    res.center_row = any_hit_next ? sum_row[SUM_W-1:2] : '0;
    res.center_col = any_hit_next ? sum_col[SUM_W-1:2] : '0;
  end

  // per-frame state
  always_ff @(posedge clk) begin
    if (rst || (step && frame_end)) begin
      row_count     <= '0;
      col_count     <= '0;
      any_hit       <= 1'b0;
      top_row       <= '0;
      bottom_row    <= '0;
      left_col      <= '0;
      right_col     <= '0;
      first_hit_col <= '0;
      last_hit_col  <= '0;
      left_col_row  <= '0;
      right_col_row <= '0;
    end else if (step) begin
      any_hit       <= any_hit_next;
      top_row       <= top_row_next;
      bottom_row    <= bottom_row_next;
      left_col      <= left_col_next;
      right_col     <= right_col_next;
      first_hit_col <= first_hit_col_next;
      last_hit_col  <= last_hit_col_next;
      left_col_row  <= left_col_row_next;
      right_col_row <= right_col_row_next;
      if (end_col) begin
        col_count <= '0;
        row_count <= row_count + DIM_W'(1);
      end else begin
        col_count <= col_count + DIM_W'(1);
      end
    end
  end

endmodule

>>> design/mepc_out.sv
`timescale 1ns / 1ps
module mepc_out (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       load,
  input  mepc_pkg::res_t             res,
  input  logic                       out_stall,
  output logic                       out_valid,
  output logic                       out_free,
  output logic [mepc_pkg::DIM_W-1:0] center_row,
  output logic [mepc_pkg::DIM_W-1:0] center_col,
  output logic                       found
);
  import mepc_pkg::*;

  res_t held;

  // slot can take a new result this cycle
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

  assign center_row = held.center_row;
  assign center_col = held.center_col;
  assign found      = held.found;

endmodule

>>> design/mask_extreme_point_center.sv
`timescale 1ns / 1ps
// Centre of a binary mask's extreme points. Mask pixels arrive in raster order,
// one per beat, and a new pixel is taken every clock unless the input stalls.
// Each pixel is first registered, then folded into the frame's running extremes
// when the input register passes it on; at the last pixel of a frame the centre
// goes to the output register and the result is valid there. Pixels keep
// flowing while a result waits downstream; input stalls only when a frame's
// last pixel meets a result that has not yet been taken. Frame size registers
// (index 0 width, index 1 height) must be written by the user only while the
// block is idle, unchecked by the block; zero reads as one, above 4096 as 4096.
module mask_extreme_point_center (
  input  logic                       clk,
  input  logic                       rst,
  // configuration
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [mepc_pkg::IDX_W-1:0] cfg_index,
  input  logic [mepc_pkg::CFG_W-1:0] cfg_data,
  // pixel stream
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [mepc_pkg::PIX_W-1:0] pixel,
  // result stream
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [mepc_pkg::DIM_W-1:0] center_row,
  output logic [mepc_pkg::DIM_W-1:0] center_col,
  output logic                       found
);
  import mepc_pkg::*;

  cfg_wr_t          cfg_wr;
  logic             in_reg_valid;
  logic [PIX_W-1:0] in_reg_pix;
  logic             frame_end, out_free, consume, load_in;
  res_t             res;

  assign cfg_ready    = 1'b1;
  assign cfg_wr.valid = cfg_valid && cfg_ready;
  assign cfg_wr.index = cfg_index;
  assign cfg_wr.data  = cfg_data;

  // held pixel moves on unless it closes a frame and the output is blocked
  assign consume  = in_reg_valid && (!frame_end || out_free);
  assign load_in  = !in_reg_valid || consume;
  assign in_stall = !load_in;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (load_in) begin
      in_reg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load_in && in_valid) begin
      in_reg_pix <= pixel;
    end
  end

  mepc_tracker u_tracker (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr    (cfg_wr),
    .step      (consume),
    .pix       (in_reg_pix),
    .frame_end (frame_end),
    .res       (res)
  );

  mepc_out u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (consume && frame_end),
    .res        (res),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .out_free   (out_free),
    .center_row (center_row),
    .center_col (center_col),
    .found      (found)
  );

  // an empty frame reports a zero centre
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !found) |-> (center_row == '0 && center_col == '0))
    else $error("empty frame with nonzero centre");

  // input only stalls behind a blocked result
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall && in_reg_valid && frame_end))
    else $error("input stalled without a blocked result");

  // an accepted pixel is held in the input register next cycle
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_reg_valid)
    else $error("accepted pixel lost");

  // a frame's result is never written over an untaken one
  assert property (@(posedge clk) disable iff (rst)
    (consume && frame_end) |-> out_free)
    else $error("result overwritten");

endmodule
